// ===== rtl/core/msfl_pkg.sv =====
// Package for the shared-store multi-stack block.
// Holds the request and response types and the status and request codes.
// No dependencies.
`default_nettype none

package msfl_pkg;

  localparam logic       REQ_PUSH = 1'b0;
  localparam logic       REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] POP_NONE = -32'sd1;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         stack_id;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/multi_stack_shared_free_list.sv =====
// Top level of the multi-stack block with a shared slot store and free list.
// Depends on msfl_pkg for the request and response types and codes.
// Holds the data, link and stack-top memories and the request sequencer.
`default_nettype none

// Several stacks share one store of SLOTS entries, linked through a free list.
// The block works on one request at a time, and each request gives exactly one
// response through an output register, so a new request is taken while a
// response still waits. A push passes through the idle and read states and loads
// its response from the read state. A pop that finds data also passes through the
// pop state and answers from there, because the top pointer must come out of the
// stack-top memory before the link and data memories can be read at that slot.
// Empty pops, full pushes and out-of-range stacks take the path of a push. A
// stalled earlier response holds the block in its last state. There is no clearing
// pass after reset: a high-water mark tells which slots have never been linked.
module multi_stack_shared_free_list #(
  parameter int SLOTS  = 64,
  parameter int STACKS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  msfl_pkg::req_t     in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output msfl_pkg::rsp_t     out_data
);
  import msfl_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [PW-1:0] END_PTR = PW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic signed [31:0] data_mem [0:SLOTS-1];
  logic [PW-1:0]      link_mem [0:SLOTS-1];
  logic [PW-1:0]      top_mem  [0:STACKS-1];

  logic [1:0]         state_r, state_nxt;
  logic [PW-1:0]      free_head_r, free_head_nxt;
  logic [PW-1:0]      hwm_r, hwm_nxt;
  logic [STACKS-1:0]  top_vld_r;
  logic               top_vld_q_r;
  logic               req_pop_r;
  logic               req_ok_r;
  logic [SW-1:0]      req_idx_r;
  logic signed [31:0] value_r;
  logic               out_valid_r;
  rsp_t               out_rsp_r;

  logic signed [31:0] data_rd_r;
  logic [PW-1:0]      link_rd_r;
  logic [PW-1:0]      top_rd_r;

  logic [31:0]        in_sid_ext;
  logic [SW-1:0]      in_idx;
  logic               in_ok;
  logic               accept;
  logic               out_free;
  logic [PW-1:0]      top_cur;
  logic               fresh;

  logic               data_we, data_re;
  logic               link_we, link_re;
  logic [AW-1:0]      link_wa, link_ra;
  logic [PW-1:0]      link_wd;
  logic               top_we;
  logic [PW-1:0]      top_wd;
  logic               load_rsp;
  rsp_t               rsp_nxt;

  assign in_sid_ext = 32'(in_data.stack_id);
  assign in_idx     = in_sid_ext[SW-1:0];
  assign in_ok      = in_sid_ext < 32'(STACKS);
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign top_cur    = top_vld_q_r ? top_rd_r : END_PTR;
  assign fresh      = (free_head_r == hwm_r);
  assign out_valid  = out_valid_r;
  assign out_data   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    hwm_nxt       = hwm_r;
    data_we       = 1'b0;
    data_re       = 1'b0;
    link_we       = 1'b0;
    link_re       = 1'b0;
    link_wa       = free_head_r[AW-1:0];
    link_ra       = free_head_r[AW-1:0];
    link_wd       = top_cur;
    top_we        = 1'b0;
    top_wd        = free_head_r;
    load_rsp      = 1'b0;
    rsp_nxt.pop_value = POP_NONE;
    rsp_nxt.status    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          link_re   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (!req_ok_r) begin
          rsp_nxt.status = req_pop_r ? ST_EMPTY : ST_FULL;
          if (out_free) begin
            load_rsp  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (req_pop_r) begin
          if (top_cur == END_PTR) begin
            rsp_nxt.status = ST_EMPTY;
            if (out_free) begin
              load_rsp  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            link_re   = 1'b1;
            link_ra   = top_cur[AW-1:0];
            data_re   = 1'b1;
            state_nxt = S_POP;
          end
        end else if (free_head_r == END_PTR) begin
          rsp_nxt.status = ST_FULL;
          if (out_free) begin
            load_rsp  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (out_free) begin
          data_we       = 1'b1;
          link_we       = 1'b1;
          top_we        = 1'b1;
          free_head_nxt = fresh ? free_head_r + PW'(1) : link_rd_r;
          hwm_nxt       = fresh ? hwm_r + PW'(1) : hwm_r;
          load_rsp      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_POP: begin
        rsp_nxt.pop_value = data_rd_r;
        if (out_free) begin
          top_we        = 1'b1;
          top_wd        = link_rd_r;
          link_we       = 1'b1;
          link_wa       = top_cur[AW-1:0];
          link_wd       = free_head_r;
          free_head_nxt = top_cur;
          load_rsp      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[free_head_r[AW-1:0]] <= value_r;
    end
    if (data_re) begin
      data_rd_r <= data_mem[top_cur[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[req_idx_r] <= top_wd;
    end
    if (accept) begin
      top_rd_r <= top_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      hwm_r       <= '0;
      top_vld_r   <= '0;
      top_vld_q_r <= 1'b0;
      req_pop_r   <= 1'b0;
      req_ok_r    <= 1'b0;
      req_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hwm_r       <= hwm_nxt;
      if (top_we) begin
        top_vld_r[req_idx_r] <= 1'b1;
      end
      if (accept) begin
        top_vld_q_r <= in_ok ? top_vld_r[in_idx] : 1'b0;
        req_pop_r   <= (in_data.req_type == REQ_POP);
        req_ok_r    <= in_ok;
        req_idx_r   <= in_idx;
      end
      if (load_rsp) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_data.push_value;
    end
    if (load_rsp) begin
      out_rsp_r <= rsp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= END_PTR) && (hwm_r <= END_PTR))
    else $error("free head or high-water mark beyond the store");

  a_pop_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> ($past(state_r) == S_RD || $past(state_r) == S_POP))
    else $error("pop completion entered without a top read");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_rsp |-> (state_r != S_IDLE) && out_free)
    else $error("response loaded outside a request or over a waiting one");

  a_fresh_take: assert property (@(posedge clk) disable iff (!rst_n)
    (top_we && state_r == S_RD && fresh) |=> (hwm_r == $past(hwm_r) + PW'(1)))
    else $error("fresh slot taken without advancing the high-water mark");
`endif

endmodule

`default_nettype wire

// ===== test/tb_multi_stack_shared_free_list.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_stack_shared_free_list: random push and pop requests
// with random idling on both channels, predicted responses checked field by field.
// Depends on msfl_pkg and the multi_stack_shared_free_list RTL.

module tb_multi_stack_shared_free_list;
  import msfl_pkg::*;

  localparam int SLOTS       = 64;
  localparam int STACKS      = 8;
  localparam int IDX_W       = $clog2(SLOTS + 1);
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 300;

  class stack_tracker;
    logic signed [31:0] slot_value[SLOTS];
    logic [IDX_W-1:0]   slot_link[SLOTS];
    logic [IDX_W-1:0]   top_slot[STACKS];
    logic [IDX_W-1:0]   free_slot;
    rsp_t               pending_rsp_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_value[i] = '0;
        slot_link[i]  = IDX_W'(i + 1);
      end
      for (int i = 0; i < STACKS; i++) begin
        top_slot[i] = IDX_W'(SLOTS);
      end
      free_slot = '0;
      errors    = 0;
    endfunction

    function void note_request(req_t req);
      rsp_t             rsp;
      logic [IDX_W-1:0] slot;
      rsp.pop_value = POP_NONE;
      rsp.status    = ST_OK;
      if (int'(req.stack_id) >= STACKS) begin
        rsp.status = (req.req_type == REQ_POP) ? ST_EMPTY : ST_FULL;
      end else if (req.req_type == REQ_POP) begin
        slot = top_slot[req.stack_id];
        if (slot == IDX_W'(SLOTS)) begin
          rsp.status = ST_EMPTY;
        end else begin
          top_slot[req.stack_id] = slot_link[slot];
          slot_link[slot]        = free_slot;
          free_slot              = slot;
          rsp.pop_value          = slot_value[slot];
        end
      end else begin
        slot = free_slot;
        if (slot == IDX_W'(SLOTS)) begin
          rsp.status = ST_FULL;
        end else begin
          free_slot              = slot_link[slot];
          slot_value[slot]       = req.push_value;
          slot_link[slot]        = top_slot[req.stack_id];
          top_slot[req.stack_id] = slot;
        end
      end
      pending_rsp_q.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual pop_value %0d status %0d",
                 $time, got.pop_value, got.status);
        errors++;
        return;
      end
      want = pending_rsp_q.pop_front();
      if (got.pop_value !== want.pop_value) begin
        $display("%0t: pop_value mismatch, expected %0d actual %0d",
                 $time, want.pop_value, got.pop_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  req_t         in_data;
  logic         out_valid;
  logic         out_stall;
  rsp_t         out_data;
  stack_tracker tracker;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           phase;

  multi_stack_shared_free_list #(
    .SLOTS (SLOTS),
    .STACKS(STACKS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_request(in_data);
      end
      if (out_valid && !out_stall) begin
        tracker.check_response(out_data);
      end
    end
  end

  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(input req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push(input int id, input logic signed [31:0] value);
    req_t req;
    req.req_type   = REQ_PUSH;
    req.stack_id   = 3'(id);
    req.push_value = value;
    send_request(req);
  endtask

  task automatic pop(input int id);
    req_t req;
    req.req_type   = REQ_POP;
    req.stack_id   = 3'(id);
    req.push_value = $urandom;
    send_request(req);
  endtask

  // Runs of mostly pushes fill the store, runs of mostly pops drain stacks to empty, and balanced runs mix both.
  task automatic run_random(input int count);
    int   left;
    int   seg;
    int   push_pct;
    req_t req;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: push_pct = 90;
        1: push_pct = 15;
        default: push_pct = 55;
      endcase
      for (int i = 0; i < seg && left > 0; i++) begin
        req.req_type   = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        req.stack_id   = 3'($urandom_range(0, STACKS - 1));
        req.push_value = $urandom;
        send_request(req);
        left--;
      end
    end
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    phase         = 0;
    send_idle_pct = 36;
    recv_idle_pct = 60;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < STACKS; i++) begin
      pop(i);
    end
    push(7, 32'sh7FFF_FFFF);
    push(0, 32'sh8000_0000);
    push(3, 32'sd0);
    push(5, -32'sd1);
    push(3, 32'sh5555_5555);
    push(3, 32'shAAAA_AAAA);
    pop(3);
    pop(3);
    pop(3);
    pop(3);
    pop(7);
    pop(0);
    pop(5);

    run_random(PHASE_ITEMS);
    phase         = 1;
    send_idle_pct = 60;
    recv_idle_pct = 36;
    run_random(PHASE_ITEMS);
    phase         = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
